>>> rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, request and command codes, and the command word that goes
// from the request front end to the screen back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEFAULT = 80;
	localparam int ROWS_DEFAULT    = 25;

	localparam int REQ_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int ATTR_W     = 8;
	localparam int IDX_W      = 11;
	localparam int POS_W      = 11;
	localparam int CELL_W     = 16;
	// Enough address bits for the largest screen (128 columns by 64 rows).
	localparam int CMD_ADDR_W = 13;

	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

	// Register index decoded from the configuration address.
	localparam logic REG_TEXT_ATTR = 1'b0;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_WRITE,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic                  scroll;
		logic [CMD_ADDR_W-1:0] addr;
		logic [CELL_W-1:0]     cell_data;
		logic [POS_W-1:0]      pos;
	} cmd_t;

	typedef struct packed {
		logic init_busy;
	} back_status_t;

endpackage
`default_nettype wire

>>> rtl/tcw_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcw_req_if;
	logic                       valid;
	logic                       ready;
	logic [tcw_pkg::REQ_W-1:0]  req_type;
	logic [tcw_pkg::CHAR_W-1:0] char_code;
	logic [tcw_pkg::IDX_W-1:0]  cell_index;

	modport source (output valid, req_type, char_code, cell_index, input ready);
	modport sink (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [tcw_pkg::POS_W-1:0]  cursor_pos;
	logic [tcw_pkg::CELL_W-1:0] read_data;
	logic                       scrolled;

	modport source (output valid, cursor_pos, read_data, scrolled, input ready);
	modport sink (input valid, cursor_pos, read_data, scrolled, output ready);
endinterface
`default_nettype wire

>>> rtl/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a command passes the two-entry queue to the back end, which steps from IDLE through
// RDWAIT for reads, COPY and a FILL of the bottom row for scrolls or FILL for clears, to DONE.
// The back end takes a new command only in IDLE, once the last one has finished, and has
// a single memory write port; scroll and clear walk the whole cell memory.
// Reset: cursor homed, attribute 0x07; a fill pass then writes spaces into every cell,
// and no request is accepted until it ends.
// ----------------------------------------------------------------------------
// Text console writer
// Teletype-style character screen with cursor, wrap, scroll, clear and cell
// reads, and a one-register configuration port for the text attribute.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tcw_req_if.sink          req,
	tcw_rsp_if.source        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	tcw_pkg::back_status_t      status;
	logic                       front_valid;
	logic                       front_ready;
	tcw_pkg::cmd_t              front_cmd;
	logic                       back_valid;
	logic                       back_ready;
	tcw_pkg::cmd_t              back_cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tcw_pkg::REG_TEXT_ATTR) ? 32'(attr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::RESET_ATTR;
		end else if (psel && penable && pwrite && pready
		             && paddr[2] == tcw_pkg::REG_TEXT_ATTR) begin
			attr_q <= pwdata[tcw_pkg::ATTR_W-1:0];
		end
	end

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.attr     (attr_q),
		.status   (status),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready),
		.cmd      (front_cmd)
	);

	tcw_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.in_cmd   (front_cmd),
		.out_valid(back_valid),
		.out_ready(back_ready),
		.out_cmd  (back_cmd)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.attr     (attr_q),
		.cmd_valid(back_valid),
		.cmd_ready(back_ready),
		.cmd      (back_cmd),
		.status   (status),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

>>> rtl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> rtl/tcw_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module tcw_cmd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tcw_pkg::cmd_t in_cmd,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tcw_pkg::cmd_t      out_cmd
);

	tcw_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule
`default_nettype wire

>>> rtl/tcw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, keeps the cursor, and turns each request into a command
// with its memory address, cell word, scroll flag and resulting cursor.
// ----------------------------------------------------------------------------
module tcw_front #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	tcw_req_if.sink                         req,
	input  wire logic [tcw_pkg::ATTR_W-1:0] attr,
	input  wire tcw_pkg::back_status_t      status,
	output logic                            cmd_valid,
	input  wire logic                       cmd_ready,
	output tcw_pkg::cmd_t                   cmd
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(COLUMNS);

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] base_q;
	logic [ROW_W-1:0]  row_n;
	logic [COL_W-1:0]  col_n;
	logic [ADDR_W-1:0] base_n;
	logic              next_line;
	logic              accept;

	// New requests wait while the screen is being cleared after reset.
	assign req.ready = cmd_ready && !status.init_busy;
	assign cmd_valid = req.valid && !status.init_busy;
	assign accept    = req.valid && req.ready;

	always_comb begin
		row_n         = row_q;
		col_n         = col_q;
		base_n        = base_q;
		next_line     = 1'b0;
		cmd.op        = tcw_pkg::OP_NOP;
		cmd.scroll    = 1'b0;
		cmd.addr      = '0;
		cmd.cell_data = '0;
		unique case (req.req_type)
			tcw_pkg::REQ_PUT: begin
				if (req.char_code == tcw_pkg::NEWLINE_CODE) begin
					col_n     = '0;
					next_line = 1'b1;
				end else begin
					cmd.op        = tcw_pkg::OP_WRITE;
					cmd.addr      = tcw_pkg::CMD_ADDR_W'(base_q + ADDR_W'(col_q));
					cmd.cell_data = {attr, req.char_code};
					if (col_q == COL_LAST) begin
						col_n     = '0;
						next_line = 1'b1;
					end else begin
						col_n = col_q + COL_W'(1);
					end
				end
				// Leaving the bottom row scrolls; the cursor stays on the bottom row.
				if (next_line) begin
					if (row_q == ROW_LAST) begin
						cmd.scroll = 1'b1;
					end else begin
						row_n  = row_q + ROW_W'(1);
						base_n = base_q + ROW_STEP;
					end
				end
			end
			tcw_pkg::REQ_READ: begin
				if (32'(req.cell_index) < 32'(CELLS)) begin
					cmd.op   = tcw_pkg::OP_READ;
					cmd.addr = tcw_pkg::CMD_ADDR_W'(req.cell_index);
				end
			end
			tcw_pkg::REQ_CLEAR: begin
				cmd.op = tcw_pkg::OP_CLEAR;
				row_n  = '0;
				col_n  = '0;
				base_n = '0;
			end
			default: begin
			end
		endcase
		cmd.pos = tcw_pkg::POS_W'(base_n + ADDR_W'(col_n));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			base_q <= '0;
		end else if (accept) begin
			row_q  <= row_n;
			col_q  <= col_n;
			base_q <= base_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/tcw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Screen back end
// Sequencer that carries out commands on the cell memory: single writes and
// reads, the scroll copy and the row and screen fills, and the response
// register.
// ----------------------------------------------------------------------------
module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [tcw_pkg::ATTR_W-1:0] attr,
	input  wire logic                       cmd_valid,
	output logic                            cmd_ready,
	input  wire tcw_pkg::cmd_t              cmd,
	output tcw_pkg::back_status_t           status,
	tcw_rsp_if.source                       rsp
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);
	localparam logic [ADDR_W-1:0] BOTTOM    = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RDWAIT = 3'd1;
	localparam logic [2:0] ST_COPY   = 3'd2;
	localparam logic [2:0] ST_FILL   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]                  state_q;
	logic                        init_q;
	logic [ADDR_W-1:0]           ptr_q;
	logic                        wb_valid_s1;
	logic [ADDR_W-1:0]           wb_addr_s1;
	tcw_pkg::cmd_t               cmd_q;
	logic [tcw_pkg::CELL_W-1:0]  rdata_q;
	logic                        out_valid_q;
	logic [tcw_pkg::POS_W-1:0]   out_pos_q;
	logic [tcw_pkg::CELL_W-1:0]  out_data_q;
	logic                        out_scroll_q;
	logic                        out_free;
	logic [tcw_pkg::CELL_W-1:0]  fill_cell;

	logic                        ram_we;
	logic [ADDR_W-1:0]           ram_waddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
	logic                        ram_re;
	logic [ADDR_W-1:0]           ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

	assign cmd_ready        = (state_q == ST_IDLE);
	assign out_free         = !out_valid_q || rsp.ready;
	assign status.init_busy = init_q;

	// The power-up fill uses the reset attribute, whatever is written meanwhile.
	assign fill_cell = init_q ? {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE}
	                          : {attr, tcw_pkg::SPACE_CODE};

	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_pos = out_pos_q;
	assign rsp.read_data  = out_data_q;
	assign rsp.scrolled   = out_scroll_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wb_addr_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = ptr_q + ROW_STEP;
		// A copy write still in flight goes first; the fill waits for it.
		priority if (wb_valid_s1) begin
			ram_we = 1'b1;
		end else if (state_q == ST_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q;
			ram_wdata = fill_cell;
		end else if (state_q == ST_IDLE && cmd_valid && cmd.op == tcw_pkg::OP_WRITE) begin
			ram_we    = 1'b1;
			ram_waddr = ADDR_W'(cmd.addr);
			ram_wdata = cmd.cell_data;
		end
		priority if (state_q == ST_IDLE && cmd_valid && cmd.op == tcw_pkg::OP_READ) begin
			ram_re    = 1'b1;
			ram_raddr = ADDR_W'(cmd.addr);
		end else if (state_q == ST_COPY) begin
			ram_re = 1'b1;
		end
	end

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			init_q      <= 1'b1;
			ptr_q       <= '0;
			wb_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wb_valid_s1 <= 1'b0;
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							tcw_pkg::OP_READ: begin
								state_q <= ST_RDWAIT;
							end
							tcw_pkg::OP_CLEAR: begin
								ptr_q   <= '0;
								state_q <= ST_FILL;
							end
							default: begin
								if (cmd.scroll) begin
									ptr_q   <= '0;
									state_q <= ST_COPY;
								end else begin
									state_q <= ST_DONE;
								end
							end
						endcase
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_DONE;
				end
				ST_COPY: begin
					// Row r+1 moves to row r, one cell a cycle, each write in the cycle after its read.
					wb_valid_s1 <= 1'b1;
					if (ptr_q == COPY_LAST) begin
						ptr_q   <= BOTTOM;
						state_q <= ST_FILL;
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				ST_FILL: begin
					if (!wb_valid_s1) begin
						if (ptr_q == CELL_LAST) begin
							init_q  <= 1'b0;
							state_q <= init_q ? ST_IDLE : ST_DONE;
						end else begin
							ptr_q <= ptr_q + ADDR_W'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wb_addr_s1 <= ptr_q;
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_RDWAIT) begin
			rdata_q <= ram_rdata;
		end
		if (state_q == ST_DONE && out_free) begin
			out_pos_q    <= cmd_q.pos;
			out_data_q   <= (cmd_q.op == tcw_pkg::OP_READ) ? rdata_q : '0;
			out_scroll_q <= cmd_q.scroll;
		end
	end

	a_wb_from_copy: assert property (@(posedge clk) disable iff (!arst_n)
		wb_valid_s1 |-> $past(state_q) == ST_COPY)
		else $error("copy write without a copy read before it");

	a_copy_trails: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY && wb_valid_s1) |-> ptr_q == wb_addr_s1 + ADDR_W'(1))
		else $error("copy write address does not trail the read by one cell");

	a_init_fill: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> state_q == ST_FILL)
		else $error("power-up fill left before it finished");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> ptr_q <= CELL_LAST)
		else $error("fill pointer beyond the screen");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !rsp.ready) |=> state_q == ST_DONE)
		else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> verif/console_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console checker
// Watches the request, response and register ports of the console writer. It
// keeps its own screen, cursor and attribute, works out the word that each
// accepted request must return, and compares returned words in order.
// ----------------------------------------------------------------------------
module console_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tcw_req_if               req,
	tcw_rsp_if               rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               errors,
	output int               pending
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam logic [2:0] ATTR_ADDR = {tcw_pkg::REG_TEXT_ATTR, 2'b00};

	typedef struct packed {
		logic [tcw_pkg::POS_W-1:0]  cursor_pos;
		logic [tcw_pkg::CELL_W-1:0] read_data;
		logic                       scrolled;
	} console_word_t;

	console_word_t              awaited_words[$];
	logic [tcw_pkg::CELL_W-1:0] screen[CELLS];
	int                         cur_row;
	int                         cur_col;
	logic [tcw_pkg::ATTR_W-1:0] text_attr;

	function automatic void fill_screen(input logic [tcw_pkg::ATTR_W-1:0] attr);
		for (int i = 0; i < CELLS; i++) begin
			screen[i] = {attr, tcw_pkg::SPACE_CODE};
		end
	endfunction

	// Updates the screen and cursor for one request and returns the word it gives.
	function automatic console_word_t predict_console_word(
			input logic [tcw_pkg::REQ_W-1:0] kind,
			input logic [tcw_pkg::CHAR_W-1:0] code,
			input logic [tcw_pkg::IDX_W-1:0] idx);
		console_word_t word;
		word = '0;
		case (kind)
			tcw_pkg::REQ_PUT: begin
				if (code == tcw_pkg::NEWLINE_CODE) begin
					cur_col = 0;
					cur_row++;
				end else begin
					screen[cur_row * COLUMNS + cur_col] = {text_attr, code};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						cur_row++;
					end
				end
				if (cur_row >= ROWS) begin
					for (int i = 0; i + COLUMNS < CELLS; i++) begin
						screen[i] = screen[i + COLUMNS];
					end
					for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
						screen[i] = {text_attr, tcw_pkg::SPACE_CODE};
					end
					cur_row = ROWS - 1;
					word.scrolled = 1'b1;
				end
			end
			tcw_pkg::REQ_READ: begin
				if (idx < CELLS) begin
					word.read_data = screen[idx];
				end
			end
			tcw_pkg::REQ_CLEAR: begin
				fill_screen(text_attr);
				cur_row = 0;
				cur_col = 0;
			end
			default: begin
			end
		endcase
		word.cursor_pos = tcw_pkg::POS_W'(cur_row * COLUMNS + cur_col);
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_word_t got;
		console_word_t want;
		if (!arst_n) begin
			fill_screen(tcw_pkg::RESET_ATTR);
			cur_row = 0;
			cur_col = 0;
			text_attr = tcw_pkg::RESET_ATTR;
			errors = 0;
			awaited_words.delete();
			pending <= 0;
		end else begin
			// Words are retired before new requests are booked; a word can never
			// belong to a request accepted at the same edge.
			if (rsp.valid && rsp.ready) begin
				got.cursor_pos = rsp.cursor_pos;
				got.read_data  = rsp.read_data;
				got.scrolled   = rsp.scrolled;
				if (awaited_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, got pos %0d data %h scrolled %b",
						$time, got.cursor_pos, got.read_data, got.scrolled);
					errors++;
				end else begin
					want = awaited_words.pop_front();
					if (got.cursor_pos !== want.cursor_pos) begin
						$display("%0t: cursor_pos expected %0d, got %0d",
							$time, want.cursor_pos, got.cursor_pos);
						errors++;
					end
					if (got.read_data !== want.read_data) begin
						$display("%0t: read_data expected %h, got %h",
							$time, want.read_data, got.read_data);
						errors++;
					end
					if (got.scrolled !== want.scrolled) begin
						$display("%0t: scrolled expected %b, got %b",
							$time, want.scrolled, got.scrolled);
						errors++;
					end
				end
			end
			if (req.valid && req.ready) begin
				awaited_words.push_back(predict_console_word(req.req_type, req.char_code,
					req.cell_index));
			end
			if (psel && penable && pwrite && pready && paddr == ATTR_ADDR) begin
				text_attr = pwdata[tcw_pkg::ATTR_W-1:0];
			end
			pending <= awaited_words.size();
		end
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives requests and attribute writes into the console writer with random
// gaps on both channels, in three idling phases and several attributes. The
// checker beside the block predicts every word; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CELLS = tcw_pkg::COLUMNS_DEFAULT * tcw_pkg::ROWS_DEFAULT;
	localparam int COLS  = tcw_pkg::COLUMNS_DEFAULT;
	localparam logic [2:0] ATTR_ADDR = {tcw_pkg::REG_TEXT_ATTR, 2'b00};
	// Code 3 is not decoded; the block only reports the cursor for it.
	localparam logic [tcw_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 645;
	localparam int CYCLE_LIMIT = 20_000_000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          cycle_count;

	tcw_req_if req_ch ();
	tcw_rsp_if rsp_ch ();

	text_console_writer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	console_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Returns at the edge where the word is taken, with valid still high.
	task automatic send_request(input logic [tcw_pkg::REQ_W-1:0] kind,
			input logic [tcw_pkg::CHAR_W-1:0] code, input logic [tcw_pkg::IDX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.char_code  <= code;
		req_ch.cell_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_attr(input logic [tcw_pkg::ATTR_W-1:0] value);
		drain();
		repeat (4) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ATTR_ADDR;
		pwdata  <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly text with an occasional newline, plus reads, clears and unused codes.
	task automatic run_random(input int count);
		int                         pick;
		logic [tcw_pkg::REQ_W-1:0]  kind;
		logic [tcw_pkg::CHAR_W-1:0] code;
		logic [tcw_pkg::IDX_W-1:0]  idx;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			code = tcw_pkg::CHAR_W'($urandom);
			idx  = tcw_pkg::IDX_W'($urandom_range(CELLS - 1));
			if (pick < 70) begin
				kind = tcw_pkg::REQ_PUT;
				if ($urandom_range(11) == 0) begin
					code = tcw_pkg::NEWLINE_CODE;
				end
			end else if (pick < 92) begin
				kind = tcw_pkg::REQ_READ;
				if ($urandom_range(7) == 0) begin
					idx = tcw_pkg::IDX_W'($urandom);
				end
			end else if (pick < 97) begin
				kind = REQ_UNUSED;
				idx  = tcw_pkg::IDX_W'($urandom);
			end else begin
				kind = tcw_pkg::REQ_CLEAR;
			end
			if ($urandom_range(299) == 0) begin
				drain();
			end
			send_request(kind, code, idx);
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = tcw_pkg::REQ_PUT;
		req_ch.char_code  = '0;
		req_ch.cell_index = '0;
		send_idle_pct     = 35;
		recv_idle_pct     = 70;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Cells after reset, both ends of the store and reads past it.
		send_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
		send_request(tcw_pkg::REQ_READ, 8'h00, 11'(CELLS - 1));
		send_request(tcw_pkg::REQ_READ, 8'h00, 11'(CELLS));
		send_request(tcw_pkg::REQ_READ, 8'h00, 11'h7FF);
		send_request(REQ_UNUSED, 8'hFF, 11'h7FF);
		send_request(tcw_pkg::REQ_PUT, 8'h00, 11'd0);
		send_request(tcw_pkg::REQ_PUT, 8'hFF, 11'h7FF);
		send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, 11'd0);
		send_request(tcw_pkg::REQ_PUT, 8'h7F, 11'd0);
		send_request(tcw_pkg::REQ_PUT, 8'h80, 11'd0);
		send_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
		send_request(tcw_pkg::REQ_READ, 8'h00, 11'd1);
		send_request(tcw_pkg::REQ_READ, 8'h00, 11'(COLS));
		write_attr(8'hFF);
		send_request(tcw_pkg::REQ_PUT, 8'h41, 11'd0);
		send_request(tcw_pkg::REQ_READ, 8'h00, 11'(COLS + 2));
		send_request(tcw_pkg::REQ_CLEAR, 8'h00, 11'd0);
		send_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);

		write_attr(8'h00);
		run_random(PHASE_ITEMS);

		write_attr(tcw_pkg::ATTR_W'($urandom));
		send_idle_pct = 70;
		recv_idle_pct = 35;
		run_random(PHASE_ITEMS);

		write_attr(8'h5A);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(PHASE_ITEMS);

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
